FILE: hdl/best_fit_block_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Checked on every edge outside reset.
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: hdl/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned ENTRY_W  = 4;
  localparam int unsigned KB_W     = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_DONE       = 2'd0,
    OUT_NO_FIT     = 2'd1,
    OUT_FULL       = 2'd2,
    OUT_NOT_FILLED = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    outcome_e              outcome;
    logic [ENTRY_W-1:0]    chosen_index;
    logic [KB_W-1:0]       block_kb;
    logic                  is_taken;
  } rsp_t;

  // clear: start a new best-fit search; sample: an entry arrives from memory
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

FILE: hdl/bfa_if.sv
interface bfa_req_if;
  import bfa_pkg::*;

  logic                  valid;
  logic                  ready;
  op_e                   op;
  logic [AMOUNT_W-1:0]   amount_kb;
  logic [ENTRY_W-1:0]    entry_index;

  modport source (output valid, op, amount_kb, entry_index, input ready);
  modport sink   (input valid, op, amount_kb, entry_index, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;

  logic                  valid;
  logic                  ready;
  outcome_e              outcome;
  logic [ENTRY_W-1:0]    chosen_index;
  logic [KB_W-1:0]       block_kb;
  logic                  is_taken;

  modport source (output valid, outcome, chosen_index, block_kb, is_taken, input ready);
  modport sink   (input valid, outcome, chosen_index, block_kb, is_taken, output ready);
endinterface

FILE: hdl/bfa_mem.sv
module bfa_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bfa_scan.sv
module bfa_scan #(
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfa_pkg::scan_ctl_t            ctl_i,
  input  logic [bfa_pkg::AMOUNT_W-1:0]  amount_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic [SIZE_BITS-1:0]          size_i,
  input  logic                          taken_i,
  output logic                          found_o,
  output logic [IDX_W-1:0]              best_idx_o,
  output logic [SIZE_BITS-1:0]          best_size_o
);
  import bfa_pkg::*;

  localparam int unsigned CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  logic                 found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [SIZE_BITS-1:0] best_size_q;
  logic                 fits;
  logic                 better;

  // strict less-than keeps the earliest entry on a tie
  assign fits   = !taken_i && (CMP_W'(size_i) >= CMP_W'(amount_i));
  assign better = fits && (!found_q || (size_i < best_size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctl_i.sample && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sample && better) begin
      best_idx_q  <= idx_i;
      best_size_q <= size_i;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_size_o = best_size_q;

endmodule

FILE: hdl/best_fit_block_allocator.sv
// Channel   Dir  Modport  Contents
// req_i     in   sink     op, amount_kb, entry_index
// rsp_o     out  source   outcome, chosen_index, block_kb, is_taken
//
// Insert, unknown requests, a read of an unfilled entry and an allocate on an empty
// table go straight to the emit state, from which rsp_o.valid is raised; a read of a filled
// entry passes the read state first. Allocate: the single memory read port visits each
// filled entry once per cycle, then the alloc state writes back the allocated mark.
// One request is in flight at a time; req_i.ready is high again once its result
// sits in the output register, even while rsp_o is stalled.
// Reset clears the block count and control state; the table needs no clearing.
`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ICMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int unsigned MEM_W  = SIZE_BITS + 1;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     scan_cnt_q;
  logic [AMOUNT_W-1:0]  amount_q;
  logic [IDX_W-1:0]     raddr_q;
  rsp_t                 res_q;
  rsp_t                 out_q;
  logic                 out_valid_q;

  logic                 req_fire;
  logic                 n_full;
  logic                 idx_ok;
  logic                 scan_more;
  logic                 out_free;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [MEM_W-1:0]     mem_rdata;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_taken;

  scan_ctl_t            scan_ctl;
  logic                 scan_found;
  logic [IDX_W-1:0]     scan_idx;
  logic [SIZE_BITS-1:0] scan_size;

  assign req_fire  = req_i.valid && req_i.ready;
  assign n_full    = (n_q == CNT_W'(MAX_BLOCKS));
  assign idx_ok    = (ICMP_W'(req_i.entry_index) < ICMP_W'(n_q));
  assign scan_more = (scan_cnt_q != n_q);
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign rd_size   = mem_rdata[SIZE_BITS-1:0];
  assign rd_taken  = mem_rdata[SIZE_BITS];

  bfa_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfa_scan #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .amount_i    (amount_q),
    .idx_i       (raddr_q),
    .size_i      (rd_size),
    .taken_i     (rd_taken),
    .found_o     (scan_found),
    .best_idx_o  (scan_idx),
    .best_size_o (scan_size)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.op)
            OP_ALLOC: state_d = (n_q == '0) ? ST_EMIT : ST_SCAN;
            OP_READ:  state_d = idx_ok ? ST_READ : ST_EMIT;
            default:  state_d = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: state_d = ST_EMIT;
      ST_READ:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: handshake, memory ports, search control
  always_comb begin
    req_i.ready     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.sample = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          case (req_i.op)
            OP_INSERT: begin
              if (!n_full) begin
                mem_we    = 1'b1;
                mem_waddr = n_q[IDX_W-1:0];
                mem_wdata = {1'b0, SIZE_BITS'(req_i.amount_kb)};
              end
            end
            OP_ALLOC: begin
              if (n_q != '0) begin
                mem_re         = 1'b1;
                scan_ctl.clear = 1'b1;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(req_i.entry_index);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_ctl.sample = 1'b1;
        if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = scan_cnt_q[IDX_W-1:0];
        end
      end
      ST_ALLOC: begin
        if (scan_found) begin
          mem_we    = 1'b1;
          mem_waddr = scan_idx;
          mem_wdata = {1'b1, scan_size};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire && (req_i.op == OP_INSERT) && !n_full) begin
        n_q <= n_q + CNT_W'(1);
      end
      if (req_fire) begin
        scan_cnt_q <= CNT_W'(1);
      end else if ((state_q == ST_SCAN) && scan_more) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      raddr_q <= mem_raddr;
    end
    if (req_fire) begin
      amount_q <= req_i.amount_kb;
      case (req_i.op)
        OP_INSERT: begin
          if (n_full) begin
            res_q <= '{outcome: OUT_FULL, chosen_index: '0, block_kb: '0, is_taken: 1'b0};
          end else begin
            res_q <= '{outcome:      OUT_DONE,
                       chosen_index: ENTRY_W'(n_q),
                       block_kb:     KB_W'(SIZE_BITS'(req_i.amount_kb)),
                       is_taken:     1'b0};
          end
        end
        OP_ALLOC: res_q <= '{outcome: OUT_NO_FIT, chosen_index: '0, block_kb: '0,
                             is_taken: 1'b0};
        OP_READ:  res_q <= '{outcome: OUT_NOT_FILLED, chosen_index: '0, block_kb: '0,
                             is_taken: 1'b0};
        default:  res_q <= '{outcome: OUT_DONE, chosen_index: '0, block_kb: '0,
                             is_taken: 1'b0};
      endcase
    end else if ((state_q == ST_ALLOC) && scan_found) begin
      res_q <= '{outcome:      OUT_DONE,
                 chosen_index: ENTRY_W'(scan_idx),
                 block_kb:     KB_W'(scan_size),
                 is_taken:     1'b1};
    end else if (state_q == ST_READ) begin
      res_q <= '{outcome:      OUT_DONE,
                 chosen_index: ENTRY_W'(raddr_q),
                 block_kb:     KB_W'(rd_size),
                 is_taken:     rd_taken};
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.outcome      = out_q.outcome;
  assign rsp_o.chosen_index = out_q.chosen_index;
  assign rsp_o.block_kb     = out_q.block_kb;
  assign rsp_o.is_taken     = out_q.is_taken;

  `BFA_ASSERT_ALWAYS(a_count_range, !rst_ni || (n_q <= CNT_W'(MAX_BLOCKS)),
    "block count beyond table depth")
  `BFA_ASSERT(a_insert_count,
    (req_fire && (req_i.op == OP_INSERT) && !n_full) |=> (n_q == ($past(n_q) + CNT_W'(1))),
    "insert did not bump block count")
  `BFA_ASSERT(a_write_slot, mem_we |-> ((state_q == ST_IDLE) || (state_q == ST_ALLOC)),
    "table written outside insert or allocate")
  `BFA_ASSERT(a_emit_hold,
    ((state_q == ST_EMIT) && out_valid_q && !rsp_o.ready) |=> (state_q == ST_EMIT),
    "result dropped while output stalled")
  `BFA_ASSERT(a_alloc_mark,
    ((state_q == ST_ALLOC) && scan_found) |=> (res_q.is_taken && (res_q.outcome == OUT_DONE)),
    "allocation result lost its mark")

endmodule
